// File: rtl/lcb_pkg.sv
// Shared types, constants and helpers for the local contrast binarizer.
package lcb_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxWindow = 7;
  localparam int unsigned MaxHeight    = 4096;
  localparam int unsigned DimW         = 13;
  localparam int unsigned PosW         = 15;
  localparam logic [7:0]  PixOn        = 8'd255;
  localparam logic [7:0]  PixOff       = 8'd0;

  typedef enum logic [2:0] {
    CfgWidth    = 3'd0,
    CfgHeight   = 3'd1,
    CfgWindow   = 3'd2,
    CfgLevels   = 3'd3,
    CfgContrast = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] gray_pixel;
    logic       is_padding;
  } lcb_in_t;

  typedef struct packed {
    logic [7:0] binary_pixel;
    logic       frame_end;
  } lcb_out_t;

  // Clamp an image dimension: zero acts as one, above the limit acts as the limit.
  function automatic logic [DimW-1:0] eff_dim(logic [DimW-1:0] v, logic [DimW-1:0] lim);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > lim) r = lim;
    return r;
  endfunction

  // Half window: even sizes fall to the lower odd size, capped at dmax.
  function automatic logic [2:0] half_win(logic [2:0] ws, logic [2:0] dmax);
    logic [2:0] d;
    d = (ws == 3'd0) ? 3'd0 : 3'((ws - 3'd1) >> 1);
    if (d > dmax) d = dmax;
    return d;
  endfunction

endpackage

// File: rtl/local_contrast_binarizer_core.sv
// Bernsen local threshold core: column line store, window registers, min/max tree.
// A pixel's result comes from the request that completes its window (d*W+d requests
// after the pixel itself, d = half window, W = width) via the B, C, D, E and output
// registers. One request per cycle unless the output stalls; the line store RAM is
// read and written back once per request, with forwarding when the same column is hit
// back to back. Reset clears counters and valids and loads the configuration defaults.
module local_contrast_binarizer_core
  import lcb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_WINDOW = DefMaxWindow
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  lcb_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output lcb_out_t    out_data_o
);

  localparam int unsigned Nw    = MAX_WINDOW;
  localparam int unsigned Lanes = MAX_WINDOW - 1;
  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam logic [2:0]  DMax  = 3'((MAX_WINDOW - 1) / 2);
  localparam logic [DimW-1:0] WLim = DimW'(MAX_WIDTH);
  localparam logic [DimW-1:0] HLim = DimW'(MaxHeight);

  // configuration registers
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [2:0]  wsize_q;
  logic [7:0]  levels_q;
  logic [7:0]  contrast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 11'd640;
      height_q   <= 13'd480;
      wsize_q    <= 3'd3;
      levels_q   <= 8'd255;
      contrast_q <= 8'd15;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWidth:    width_q    <= cfg_data_i[10:0];
        CfgHeight:   height_q   <= cfg_data_i;
        CfgWindow:   wsize_q    <= cfg_data_i[2:0];
        CfgLevels:   levels_q   <= cfg_data_i[7:0];
        CfgContrast: contrast_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [DimW-1:0] w_eff, h_eff;
  logic [2:0]      d;
  assign w_eff = eff_dim({2'b0, width_q}, WLim);
  assign h_eff = eff_dim(height_q, HLim);
  assign d     = half_win(wsize_q, DMax);

  // global advance: whole pipeline moves when the output register can take data
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage A: position and masks ----------------
  logic [ColW-1:0] in_col_q;
  logic [DimW-1:0] in_row_q;
  logic            acc, drop, adv;
  logic [PosW-1:0] back_sum;
  logic [2:0]      back_rows;
  logic signed [PosW-1:0] p_row;
  logic [PosW-1:0]  p_col;
  logic             emit, past_end, fend;
  logic [Nw-1:0]    rmask, cmask;
  logic [DimW-1:0]  col_inc;

  assign acc    = in_valid_i && en;
  assign drop   = in_data_i.is_padding && (in_row_q < h_eff);
  assign adv    = acc && !drop;

  // step back d columns, borrowing whole lines as often as a narrow image needs
  always_comb begin
    back_sum  = '0;
    back_rows = '0;
    for (int i = 0; i < int'(DMax); i++) begin
      if (PosW'(in_col_q) + back_sum < PosW'(d)) begin
        back_sum  = back_sum + PosW'(w_eff);
        back_rows = back_rows + 3'd1;
      end
    end
  end

  assign p_row  = $signed({2'b0, in_row_q}) - $signed(PosW'(d)) - $signed(PosW'(back_rows));
  assign p_col  = PosW'(in_col_q) + back_sum - PosW'(d);
  assign emit     = (p_row >= 0) && (p_row < $signed({2'b0, h_eff}));
  assign past_end = (p_row >= 0) && !emit;
  assign fend     = emit && (p_row == $signed({2'b0, h_eff}) - 1)
                    && (p_col == PosW'(w_eff) - 1);
  assign col_inc  = DimW'(in_col_q) + DimW'(1);

  always_comb begin
    logic signed [PosW-1:0] rr, cc;
    for (int j = 0; j < Nw; j++) begin
      rr = p_row + $signed(PosW'(d)) - $signed(PosW'(j));
      rmask[j] = (PosW'(j) <= PosW'({d, 1'b0})) && (rr >= 0)
                 && (rr < $signed({2'b0, h_eff}));
      cc = $signed(p_col) + $signed(PosW'(d)) - $signed(PosW'(j));
      cmask[j] = (PosW'(j) <= PosW'({d, 1'b0})) && (cc >= 0)
                 && (cc < $signed({2'b0, w_eff}));
    end
  end

  // advance the raster position, wrap at frame end or overrun
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (adv) begin
      if (fend || past_end) begin
        in_col_q <= '0;
        in_row_q <= '0;
      end else if (col_inc >= w_eff) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + DimW'(1);
      end else begin
        in_col_q <= ColW'(col_inc);
      end
    end
  end

  // ---------------- stage B: line store read-modify-write ----------------
  logic            b_valid_q, b_emit_q, b_fend_q;
  logic [ColW-1:0] b_col_q;
  logic [7:0]      b_pix_q;
  logic [Nw-1:0]   b_rmask_q, b_cmask_q;
  logic [8*Lanes-1:0] ram_rdata, lanes, wb_data, fwd_data_q;
  logic            fwd_q, ram_we;

  assign lanes   = fwd_q ? fwd_data_q : ram_rdata;
  assign wb_data = {lanes[8*Lanes-9:0], b_pix_q};
  assign ram_we  = en && b_valid_q;

  lcb_ram #(
    .Width(8 * Lanes),
    .Depth(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(b_col_q),
    .wdata_i(wb_data),
    .re_i   (en),
    .raddr_i(in_col_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (en) begin
      b_valid_q <= adv && !past_end;
      fwd_q     <= b_valid_q && (b_col_q == in_col_q);
    end
  end

  // stage B payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_emit_q   <= emit;
      b_fend_q   <= fend;
      b_col_q    <= in_col_q;
      b_pix_q    <= in_data_i.gray_pixel;
      b_rmask_q  <= rmask;
      b_cmask_q  <= cmask;
      fwd_data_q <= wb_data;
    end
  end

  // window registers: shift in the new column (row offset 0 is the newest row)
  logic [7:0] win_q [Nw][Nw];
  always_ff @(posedge clk_i) begin
    if (en && b_valid_q) begin
      for (int s = Nw - 1; s > 0; s--) begin
        for (int j = 0; j < Nw; j++) win_q[s][j] <= win_q[s-1][j];
      end
      win_q[0][0] <= b_pix_q;
      for (int j = 1; j < Nw; j++) win_q[0][j] <= lanes[8*(j-1) +: 8];
    end
  end

  // ---------------- stage C: per-column min and max ----------------
  logic          c_valid_q, c_fend_q;
  logic [Nw-1:0] c_rmask_q, c_cmask_q;
  logic [7:0]    col_min [Nw];
  logic [7:0]    col_max [Nw];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_valid_q <= 1'b0;
    else if (en) c_valid_q <= b_valid_q && b_emit_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_fend_q  <= b_fend_q;
      c_rmask_q <= b_rmask_q;
      c_cmask_q <= b_cmask_q;
    end
  end

  always_comb begin
    for (int s = 0; s < Nw; s++) begin
      col_min[s] = levels_q;
      col_max[s] = 8'd0;
      for (int j = 0; j < Nw; j++) begin
        if (c_rmask_q[j]) begin
          if (win_q[s][j] < col_min[s]) col_min[s] = win_q[s][j];
          if (win_q[s][j] > col_max[s]) col_max[s] = win_q[s][j];
        end
      end
    end
  end

  // ---------------- stage D: combine columns ----------------
  logic          d_valid_q, d_fend_q;
  logic [7:0]    d_cmin_q [Nw];
  logic [7:0]    d_cmax_q [Nw];
  logic [Nw-1:0] d_cmask_q;
  logic [7:0]    d_center_q;
  logic [7:0]    vmin, vmax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_valid_q <= 1'b0;
    else if (en) d_valid_q <= c_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_fend_q   <= c_fend_q;
      d_cmask_q  <= c_cmask_q;
      d_center_q <= win_q[d][d];
      for (int s = 0; s < Nw; s++) begin
        d_cmin_q[s] <= col_min[s];
        d_cmax_q[s] <= col_max[s];
      end
    end
  end

  always_comb begin
    vmin = levels_q;
    vmax = 8'd0;
    for (int s = 0; s < Nw; s++) begin
      if (d_cmask_q[s]) begin
        if (d_cmin_q[s] < vmin) vmin = d_cmin_q[s];
        if (d_cmax_q[s] > vmax) vmax = d_cmax_q[s];
      end
    end
  end

  // ---------------- stage E: threshold and output register ----------------
  logic [7:0] e_min_q, e_max_q, e_center_q;
  logic       e_valid_q, e_fend_q;
  logic [8:0] sum;
  logic [7:0] thr;
  logic signed [9:0] diff;
  lcb_out_t   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_valid_q <= 1'b0;
    else if (en) e_valid_q <= d_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_min_q    <= vmin;
      e_max_q    <= vmax;
      e_center_q <= d_center_q;
      e_fend_q   <= d_fend_q;
    end
  end

  assign diff = $signed({2'b0, e_max_q}) - $signed({2'b0, e_min_q});
  assign sum  = {1'b0, e_min_q} + {1'b0, e_max_q};
  assign thr  = (diff < $signed({2'b0, contrast_q})) ? (levels_q >> 1) : sum[8:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= e_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.binary_pixel <= (e_center_q > thr) ? PixOn : PixOff;
      out_q.frame_end    <= e_fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_bin_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.binary_pixel == PixOn || out_data_o.binary_pixel == PixOff))
    else $error("result pixel not binary");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_q && !out_ready_i))
    else $error("input stalled with free output register");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({{(DimW-ColW){1'b0}}, in_col_q} < WLim))
    else $error("column counter out of range");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(e_valid_q) && $stable(b_valid_q))
    else $error("pipeline moved during stall");

endmodule

// File: rtl/lcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
